/* design/mrrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the
// response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    localparam int MAX_REGS  = 125;
    localparam int MAX_FRAME = 255;

    localparam logic [7:0]  FN_READ        = 8'h03;
    localparam logic [7:0]  FN_WRITE       = 8'h10;
    localparam logic [8:0]  WRITE_RESP_LEN = 9'd8;
    localparam logic [8:0]  READ_OVERHEAD  = 9'd5;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic [7:0] MAX_FRAME_B = 8'(MAX_FRAME);
    localparam logic [6:0] MAX_REGS_B  = 7'(MAX_REGS);

    typedef enum logic [1:0] {
        CFG_SLAVE_ADDRESS    = 2'd0,
        CFG_WRITE_MODE       = 2'd1,
        CFG_REGISTER_ADDRESS = 2'd2,
        CFG_REGISTER_COUNT   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_HEADER    = 3'd2,
        VERDICT_CRC       = 3'd3,
        VERDICT_FIELD     = 3'd4
    } verdict_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic        write_mode;
        logic [15:0] register_address;
        logic [6:0]  register_count;
    } cfg_t;

    typedef struct packed {
        logic         valid;
        result_kind_t kind;
        logic [7:0]   payload_byte;
        logic [7:0]   payload_index;
        verdict_t     verdict;
        logic [7:0]   frame_length;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

/* design/mrrc_cfg.sv */
// ----------------------------------------------------------------------------
// mrrc_cfg
// Configuration register file: slave address, mode, register address and
// register count, written through the configuration channel.
// ----------------------------------------------------------------------------
module mrrc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output mrrc_pkg::cfg_t      cfg
);

    mrrc_pkg::cfg_t cfg_reg;
    mrrc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (mrrc_pkg::cfg_index_t'(cfg_index))
                mrrc_pkg::CFG_SLAVE_ADDRESS:    cfg_next.slave_address    = cfg_data[7:0];
                mrrc_pkg::CFG_WRITE_MODE:       cfg_next.write_mode       = cfg_data[0];
                mrrc_pkg::CFG_REGISTER_ADDRESS: cfg_next.register_address = cfg_data;
                mrrc_pkg::CFG_REGISTER_COUNT:   cfg_next.register_count   = cfg_data[6:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address    <= 8'd1;
            cfg_reg.write_mode       <= 1'b0;
            cfg_reg.register_address <= 16'd0;
            cfg_reg.register_count   <= 7'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/mrrc_frame.sv */
// ----------------------------------------------------------------------------
// mrrc_frame
// Frame state (position, CRC, delay line, mismatch flags) and the
// per-byte checks that produce a payload byte or an end-of-frame verdict.
// ----------------------------------------------------------------------------
module mrrc_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          rx_byte,
    input  logic                frame_end,
    input  mrrc_pkg::cfg_t      cfg,
    output mrrc_pkg::result_t   result
);

    logic [7:0]  pos_reg,       pos_next;
    logic [15:0] crc_reg,       crc_next;
    logic [7:0]  d0_reg,        d0_next;
    logic [7:0]  d1_reg,        d1_next;
    logic        hdr_mis_reg,   hdr_mis_next;
    logic        fld_mis_reg,   fld_mis_next;

    logic        count_ok;
    logic [7:0]  data_bytes;
    logic [8:0]  min_len;
    logic        kept;
    logic        emit;
    logic [15:0] crc_rx;
    logic [7:0]  fn_expected;

    always_comb
    begin
        count_ok    = (cfg.register_count != 7'd0) &&
                      (cfg.register_count <= mrrc_pkg::MAX_REGS_B);
        data_bytes  = {cfg.register_count, 1'b0};
        min_len     = cfg.write_mode ? mrrc_pkg::WRITE_RESP_LEN
                                     : mrrc_pkg::READ_OVERHEAD + {1'b0, data_bytes};
        fn_expected = cfg.write_mode ? mrrc_pkg::FN_WRITE : mrrc_pkg::FN_READ;
        kept        = pos_reg < mrrc_pkg::MAX_FRAME_B;

        pos_next     = pos_reg;
        crc_next     = crc_reg;
        d0_next      = d0_reg;
        d1_next      = d1_reg;
        hdr_mis_next = hdr_mis_reg;
        fld_mis_next = fld_mis_reg;
        emit         = 1'b0;

        if (kept)
        begin
            if (pos_reg == 8'd0 && rx_byte != cfg.slave_address)
                hdr_mis_next = 1'b1;
            if (pos_reg == 8'd1 && rx_byte != fn_expected)
                hdr_mis_next = 1'b1;
            if (cfg.write_mode)
            begin
                if (pos_reg == 8'd2 && rx_byte != cfg.register_address[15:8])
                    fld_mis_next = 1'b1;
                if (pos_reg == 8'd3 && rx_byte != cfg.register_address[7:0])
                    fld_mis_next = 1'b1;
                if (pos_reg == 8'd4 && rx_byte != 8'd0)
                    fld_mis_next = 1'b1;
                if (pos_reg == 8'd5 && rx_byte != {1'b0, cfg.register_count})
                    fld_mis_next = 1'b1;
            end
            else
            begin
                if (pos_reg == 8'd2 && rx_byte != data_bytes)
                    fld_mis_next = 1'b1;
                if (count_ok && pos_reg >= 8'd3 &&
                    {1'b0, pos_reg} < 9'd3 + {1'b0, data_bytes})
                    emit = 1'b1;
            end
            if (pos_reg >= 8'd2)
                crc_next = mrrc_pkg::crc_feed(crc_reg, d1_reg);
            d1_next  = d0_reg;
            d0_next  = rx_byte;
            pos_next = pos_reg + 8'd1;
        end

        crc_rx = {d0_next, d1_next};

        result.valid         = frame_end || emit;
        result.kind          = frame_end ? mrrc_pkg::KIND_VERDICT : mrrc_pkg::KIND_PAYLOAD;
        result.payload_byte  = frame_end ? 8'd0 : rx_byte;
        result.payload_index = frame_end ? 8'd0 : pos_reg - 8'd3;
        result.frame_length  = frame_end ? pos_next : 8'd0;
        if (!frame_end)
            result.verdict = mrrc_pkg::VERDICT_OK;
        else if ({1'b0, pos_next} < min_len)
            result.verdict = mrrc_pkg::VERDICT_SHORT;
        else if (hdr_mis_next)
            result.verdict = mrrc_pkg::VERDICT_HEADER;
        else if (crc_rx != crc_next)
            result.verdict = mrrc_pkg::VERDICT_CRC;
        else if (fld_mis_next || !count_ok)
            result.verdict = mrrc_pkg::VERDICT_FIELD;
        else
            result.verdict = mrrc_pkg::VERDICT_OK;

        if (frame_end)
        begin
            pos_next     = 8'd0;
            crc_next     = mrrc_pkg::CRC_INIT;
            d0_next      = 8'd0;
            d1_next      = 8'd0;
            hdr_mis_next = 1'b0;
            fld_mis_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 8'd0;
            crc_reg     <= mrrc_pkg::CRC_INIT;
            d0_reg      <= 8'd0;
            d1_reg      <= 8'd0;
            hdr_mis_reg <= 1'b0;
            fld_mis_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            d0_reg      <= d0_next;
            d1_reg      <= d1_next;
            hdr_mis_reg <= hdr_mis_next;
            fld_mis_reg <= fld_mis_next;
        end
    end

endmodule

/* design/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks received Modbus RTU responses byte by byte and reports payload
// bytes and one verdict per frame.
// ----------------------------------------------------------------------------
// Accepts one response byte per cycle; each byte passes an input register,
// the combinational checks and CRC-16 byte update, and an output register,
// from which its result is offered; the throughput is one byte per clock
// while the output side keeps up. In read mode, with a valid register count,
// every register data byte is emitted as it arrives and counts only if the
// frame's verdict is OK; the frame's last byte always yields a verdict.
// Write the configuration only while no frame is in flight.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [18:16] verdict,
    // [26:19] frame_length, [31:27] zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] result_kind

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mrrc_pkg::cfg_t    cfg;
    mrrc_pkg::result_t result;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    mrrc_pkg::result_t out_reg;
    logic              advance;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    mrrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mrrc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rx_byte   (in_byte_reg),
        .frame_end (in_last_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= result.valid;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {5'd0, out_reg.frame_length, out_reg.verdict,
                            out_reg.payload_index, out_reg.payload_byte};

endmodule
